[hw/rtl/hsv_hls_to_rgb_converter_macros.svh]
`ifndef HSV_HLS_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_HLS_TO_RGB_CONVERTER_MACROS_SVH

// Check a condition in the same cycle as its trigger
`define HHR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger
`define HHR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/hhr_pkg.sv]
package hhr_pkg;

    // Fixed point format: FRAC_BITS fraction bits, ONE stands for 1.0
    localparam int FRAC_BITS = 12;
    localparam int HUE_W     = FRAC_BITS;
    localparam int VAL_W     = FRAC_BITS + 1;
    localparam int X_W       = FRAC_BITS + 3;
    localparam int MAG_W     = FRAC_BITS + 2;
    localparam int BASE_W    = FRAC_BITS + 3;
    localparam int SUM_W     = FRAC_BITS + 4;
    localparam int SEXT_W    = X_W - FRAC_BITS;
    localparam int NUM_CH    = 3;

    localparam logic [VAL_W-1:0] ONE  = VAL_W'(1) << FRAC_BITS;
    localparam logic [VAL_W-1:0] HALF = VAL_W'(1) << (FRAC_BITS - 1);

    // Channel order
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef enum logic [0:0] {
        SPACE_HSV = 1'b0,
        SPACE_HLS = 1'b1
    } t_space;

    // Front end result: scaled hue split, clamped inputs, first products
    typedef struct packed {
        t_space                   space;
        logic [SEXT_W-1:0]        sext;
        logic [VAL_W-1:0]         sat;
        logic [VAL_W-1:0]         val;
        logic [VAL_W-1:0]         sf;
        logic [VAL_W-1:0]         sg;
        logic [VAL_W-1:0]         ls;
        logic [NUM_CH-1:0][VAL_W-1:0] wgt;
    } t_front;

    // Per channel operands: result = base +/- (mag_a * mag_b) >> FRAC_BITS
    typedef struct packed {
        logic signed [BASE_W-1:0] base;
        logic [MAG_W-1:0]         mag_a;
        logic [VAL_W-1:0]         mag_b;
        logic                     neg;
    } t_chan;

    typedef t_chan [NUM_CH-1:0] t_chan_vec;

    // Per channel product awaiting the final sum
    typedef struct packed {
        logic signed [BASE_W-1:0] base;
        logic [MAG_W-1:0]         prod;
        logic                     neg;
    } t_prod;

endpackage

[hw/rtl/hsv_hls_to_rgb_converter.sv]
// Five register stages; a request passes through the front end, select and combine.
// Throughput: one pixel per cycle unless the output stalls; each of the five stages
// has its own valid bit, and ready ripples back so an empty stage keeps taking
// requests under a stall.
// Reset (synchronous, active low) empties every stage and selects HSV as source space.
// The source space is sampled when a pixel enters; change it only while the block is idle.
module hsv_hls_to_rgb_converter (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [hhr_pkg::HUE_W-1:0] i_hue,
    input  logic [hhr_pkg::VAL_W-1:0] i_saturation,
    input  logic [hhr_pkg::VAL_W-1:0] i_value_or_lightness,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [hhr_pkg::VAL_W-1:0] o_red,
    output logic [hhr_pkg::VAL_W-1:0] o_green,
    output logic [hhr_pkg::VAL_W-1:0] o_blue,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_data
);

    hhr_pkg::t_space    r_space;
    logic               front_vld;
    logic               front_rdy;
    hhr_pkg::t_front    front;
    logic               sel_vld;
    logic               sel_rdy;
    hhr_pkg::t_chan_vec chan;

    // Hold the source space register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_space <= hhr_pkg::SPACE_HSV;
        end else if (i_cfg_we) begin
            r_space <= hhr_pkg::t_space'(i_cfg_data);
        end
    end

    hhr_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_hue                (i_hue),
        .i_saturation         (i_saturation),
        .i_value_or_lightness (i_value_or_lightness),
        .i_space              (r_space),
        .o_valid              (front_vld),
        .i_ready              (front_rdy),
        .o_front              (front)
    );

    hhr_select u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_vld),
        .o_ready (front_rdy),
        .i_front (front),
        .o_valid (sel_vld),
        .i_ready (sel_rdy),
        .o_chan  (chan)
    );

    hhr_combine u_combine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sel_vld),
        .o_ready (sel_rdy),
        .i_chan  (chan),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

endmodule

[hw/rtl/hhr_front.sv]
`include "hsv_hls_to_rgb_converter_macros.svh"

module hhr_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [hhr_pkg::HUE_W-1:0] i_hue,
    input  logic [hhr_pkg::VAL_W-1:0] i_saturation,
    input  logic [hhr_pkg::VAL_W-1:0] i_value_or_lightness,
    input  hhr_pkg::t_space           i_space,
    output logic                      o_valid,
    input  logic                      i_ready,
    output hhr_pkg::t_front           o_front
);

    localparam int Y_W = hhr_pkg::X_W + 1;
    localparam logic [Y_W-1:0] Y_ONE   = Y_W'(1) << hhr_pkg::FRAC_BITS;
    localparam logic [Y_W-1:0] Y_TWO   = Y_W'(2) << hhr_pkg::FRAC_BITS;
    localparam logic [Y_W-1:0] Y_THREE = Y_W'(3) << hhr_pkg::FRAC_BITS;
    localparam logic [Y_W-1:0] Y_FOUR  = Y_W'(4) << hhr_pkg::FRAC_BITS;
    localparam logic [Y_W-1:0] Y_SIX   = Y_W'(6) << hhr_pkg::FRAC_BITS;
    localparam logic [hhr_pkg::X_W-1:0] X_SIX = hhr_pkg::X_W'(6) << hhr_pkg::FRAC_BITS;
    localparam int PR_W = 2 * hhr_pkg::VAL_W;

    typedef struct packed {
        hhr_pkg::t_space           space;
        logic [hhr_pkg::X_W-1:0]   x;
        logic [hhr_pkg::VAL_W-1:0] sat;
        logic [hhr_pkg::VAL_W-1:0] val;
    } t_in;

    function automatic logic [hhr_pkg::VAL_W-1:0] clamp_one(
        input logic [hhr_pkg::VAL_W-1:0] a
    );
        return (a > hhr_pkg::ONE) ? hhr_pkg::ONE : a;
    endfunction

    // Bring a shifted hue back into one turn
    function automatic logic [Y_W-1:0] wrap_turn(input logic [Y_W-1:0] y);
        return (y >= Y_SIX) ? (y - Y_SIX) : y;
    endfunction

    // Ramp weight: rise over the first sextant, flat top, fall over the fourth
    function automatic logic [hhr_pkg::VAL_W-1:0] ramp_weight(input logic [Y_W-1:0] y);
        logic [Y_W-1:0] fall;
        fall = Y_FOUR - y;
        if (y < Y_ONE) begin
            return y[hhr_pkg::VAL_W-1:0];
        end else if (y < Y_THREE) begin
            return hhr_pkg::ONE;
        end else if (y < Y_FOUR) begin
            return fall[hhr_pkg::VAL_W-1:0];
        end else begin
            return '0;
        end
    endfunction

    logic                      r_s1_vld;
    t_in                       r_s1;
    t_in                       n_s1;
    logic                      s1_rdy;
    logic                      r_s2_vld;
    hhr_pkg::t_front           r_s2;
    hhr_pkg::t_front           n_s2;
    logic                      s2_rdy;
    logic [hhr_pkg::FRAC_BITS-1:0] frac;
    logic [hhr_pkg::VAL_W-1:0] frac_inv;
    logic [PR_W-1:0]           pr_sf;
    logic [PR_W-1:0]           pr_sg;
    logic [PR_W-1:0]           pr_ls;
    logic [Y_W-1:0]            y_red;
    logic [Y_W-1:0]            y_green;
    logic [Y_W-1:0]            y_blue;

    assign s2_rdy  = !r_s2_vld || i_ready;
    assign s1_rdy  = !r_s1_vld || s2_rdy;
    assign o_ready = s1_rdy;

    // Clamp inputs and scale hue by six
    always_comb begin
        n_s1.space = i_space;
        n_s1.x     = (hhr_pkg::X_W'(i_hue) << 2) + (hhr_pkg::X_W'(i_hue) << 1);
        n_s1.sat   = clamp_one(i_saturation);
        n_s1.val   = clamp_one(i_value_or_lightness);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_rdy) begin
            r_s1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && s1_rdy) begin
            r_s1 <= n_s1;
        end
    end

    // Form the saturation products and the ramp weights
    always_comb begin
        frac     = r_s1.x[hhr_pkg::FRAC_BITS-1:0];
        frac_inv = hhr_pkg::ONE - hhr_pkg::VAL_W'(frac);
        pr_sf    = PR_W'(r_s1.sat) * PR_W'(frac);
        pr_sg    = PR_W'(r_s1.sat) * PR_W'(frac_inv);
        pr_ls    = PR_W'(r_s1.sat) * PR_W'(r_s1.val);
        y_green  = Y_W'(r_s1.x);
        y_red    = wrap_turn(Y_W'(r_s1.x) + Y_TWO);
        y_blue   = wrap_turn(Y_W'(r_s1.x) + Y_FOUR);

        n_s2.space = r_s1.space;
        n_s2.sext  = r_s1.x[hhr_pkg::X_W-1:hhr_pkg::FRAC_BITS];
        n_s2.sat   = r_s1.sat;
        n_s2.val   = r_s1.val;
        n_s2.sf    = pr_sf[hhr_pkg::FRAC_BITS +: hhr_pkg::VAL_W];
        n_s2.sg    = pr_sg[hhr_pkg::FRAC_BITS +: hhr_pkg::VAL_W];
        n_s2.ls    = pr_ls[hhr_pkg::FRAC_BITS +: hhr_pkg::VAL_W];
        n_s2.wgt[hhr_pkg::CH_RED]   = ramp_weight(y_red);
        n_s2.wgt[hhr_pkg::CH_GREEN] = ramp_weight(y_green);
        n_s2.wgt[hhr_pkg::CH_BLUE]  = ramp_weight(y_blue);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (s2_rdy) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld && s2_rdy) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_s2_vld;
    assign o_front = r_s2;

    `HHR_ASSERT_NOW(a_hue_in_turn, r_s1_vld, r_s1.x < X_SIX, "scaled hue beyond one turn")
    `HHR_ASSERT_NOW(a_prod_bound, r_s2_vld,
        (r_s2.sf <= r_s2.sat) && (r_s2.sg <= r_s2.sat) && (r_s2.ls <= r_s2.sat),
        "saturation product exceeds saturation")

endmodule

[hw/rtl/hhr_select.sv]
`include "hsv_hls_to_rgb_converter_macros.svh"

module hhr_select (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  hhr_pkg::t_front    i_front,
    output logic               o_valid,
    input  logic               i_ready,
    output hhr_pkg::t_chan_vec o_chan
);

    localparam logic [hhr_pkg::SEXT_W-1:0] SEXT_RED_RISE   = 3'd0;
    localparam logic [hhr_pkg::SEXT_W-1:0] SEXT_GREEN_TOP  = 3'd1;
    localparam logic [hhr_pkg::SEXT_W-1:0] SEXT_BLUE_RISE  = 3'd2;
    localparam logic [hhr_pkg::SEXT_W-1:0] SEXT_GREEN_FALL = 3'd3;
    localparam logic [hhr_pkg::SEXT_W-1:0] SEXT_RED_RETURN = 3'd4;

    logic                      r_vld;
    hhr_pkg::t_chan_vec        r_chan;
    hhr_pkg::t_chan_vec        n_chan;
    logic [hhr_pkg::VAL_W-1:0] b_p1;
    logic [hhr_pkg::VAL_W-1:0] b_p2;
    logic [hhr_pkg::VAL_W-1:0] b_p3;
    logic [hhr_pkg::NUM_CH-1:0][hhr_pkg::VAL_W-1:0] hsv_b;
    logic signed [hhr_pkg::BASE_W-1:0] l_s;
    logic signed [hhr_pkg::BASE_W-1:0] s_s;
    logic signed [hhr_pkg::BASE_W-1:0] ls_s;
    logic signed [hhr_pkg::BASE_W-1:0] m2;
    logic signed [hhr_pkg::BASE_W-1:0] m1;
    logic signed [hhr_pkg::BASE_W-1:0] d;
    logic signed [hhr_pkg::BASE_W-1:0] d_abs;

    assign o_ready = !r_vld || i_ready;

    // Pick the HSV multiplier operand of each channel by sextant
    always_comb begin
        b_p1 = hhr_pkg::ONE - i_front.sat;
        b_p2 = hhr_pkg::ONE - i_front.sf;
        b_p3 = hhr_pkg::ONE - i_front.sg;
        unique case (i_front.sext)
            SEXT_RED_RISE: begin
                hsv_b = {b_p1, b_p3, hhr_pkg::ONE};
            end
            SEXT_GREEN_TOP: begin
                hsv_b = {b_p1, hhr_pkg::ONE, b_p2};
            end
            SEXT_BLUE_RISE: begin
                hsv_b = {b_p3, hhr_pkg::ONE, b_p1};
            end
            SEXT_GREEN_FALL: begin
                hsv_b = {hhr_pkg::ONE, b_p2, b_p1};
            end
            SEXT_RED_RETURN: begin
                hsv_b = {hhr_pkg::ONE, b_p1, b_p3};
            end
            default: begin
                hsv_b = {b_p2, b_p1, hhr_pkg::ONE};
            end
        endcase
    end

    // Derive the HLS levels m1 and m2
    always_comb begin
        l_s  = $signed(hhr_pkg::BASE_W'(i_front.val));
        s_s  = $signed(hhr_pkg::BASE_W'(i_front.sat));
        ls_s = $signed(hhr_pkg::BASE_W'(i_front.ls));
        if (i_front.val <= hhr_pkg::HALF) begin
            m2 = l_s + ls_s;
        end else begin
            m2 = l_s + s_s - ls_s;
        end
        m1    = l_s + l_s - m2;
        d     = m2 - m1;
        d_abs = d[hhr_pkg::BASE_W-1] ? -d : d;
    end

    // Assemble the per channel operands
    always_comb begin
        for (int c = 0; c < hhr_pkg::NUM_CH; c++) begin
            if (i_front.space == hhr_pkg::SPACE_HSV) begin
                n_chan[c].base  = '0;
                n_chan[c].mag_a = hhr_pkg::MAG_W'(i_front.val);
                n_chan[c].mag_b = hsv_b[c];
                n_chan[c].neg   = 1'b0;
            end else begin
                n_chan[c].base  = m1;
                n_chan[c].mag_a = d_abs[hhr_pkg::MAG_W-1:0];
                n_chan[c].mag_b = i_front.wgt[c];
                n_chan[c].neg   = d[hhr_pkg::BASE_W-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_chan <= n_chan;
        end
    end

    assign o_valid = r_vld;
    assign o_chan  = r_chan;

    `HHR_ASSERT_NOW(a_weight_bound, r_vld,
        (r_chan[0].mag_b <= hhr_pkg::ONE) && (r_chan[1].mag_b <= hhr_pkg::ONE) &&
        (r_chan[2].mag_b <= hhr_pkg::ONE), "multiplier operand above one")
    `HHR_ASSERT_NOW(a_levels_nonneg, r_vld,
        !r_chan[0].neg && !r_chan[1].neg && !r_chan[2].neg &&
        !r_chan[0].base[hhr_pkg::BASE_W-1] && !r_chan[1].base[hhr_pkg::BASE_W-1] &&
        !r_chan[2].base[hhr_pkg::BASE_W-1], "negative level or slope")
    `HHR_ASSERT_NEXT(a_stall_holds, r_vld && !i_ready, r_vld && $stable(r_chan),
        "stalled stage lost or changed its request")

endmodule

[hw/rtl/hhr_combine.sv]
`include "hsv_hls_to_rgb_converter_macros.svh"

module hhr_combine (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  hhr_pkg::t_chan_vec        i_chan,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [hhr_pkg::VAL_W-1:0] o_red,
    output logic [hhr_pkg::VAL_W-1:0] o_green,
    output logic [hhr_pkg::VAL_W-1:0] o_blue
);

    localparam int PR_W = hhr_pkg::MAG_W + hhr_pkg::VAL_W;

    logic                      r_p_vld;
    hhr_pkg::t_prod [hhr_pkg::NUM_CH-1:0] r_p;
    hhr_pkg::t_prod [hhr_pkg::NUM_CH-1:0] n_p;
    logic                      p_rdy;
    logic                      r_o_vld;
    logic [hhr_pkg::NUM_CH-1:0][hhr_pkg::VAL_W-1:0] r_out;
    logic [hhr_pkg::NUM_CH-1:0][hhr_pkg::VAL_W-1:0] n_out;
    logic                      o_rdy;
    logic [hhr_pkg::NUM_CH-1:0][PR_W-1:0] prod;
    logic signed [hhr_pkg::NUM_CH-1:0][hhr_pkg::SUM_W-1:0] sum;

    assign o_rdy   = !r_o_vld || i_ready;
    assign p_rdy   = !r_p_vld || o_rdy;
    assign o_ready = p_rdy;

    // Multiply each channel, drop the fraction bits
    always_comb begin
        for (int c = 0; c < hhr_pkg::NUM_CH; c++) begin
            prod[c]      = PR_W'(i_chan[c].mag_a) * PR_W'(i_chan[c].mag_b);
            n_p[c].base  = i_chan[c].base;
            n_p[c].prod  = prod[c][hhr_pkg::FRAC_BITS +: hhr_pkg::MAG_W];
            n_p[c].neg   = i_chan[c].neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (p_rdy) begin
            r_p_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && p_rdy) begin
            r_p <= n_p;
        end
    end

    // Add to the base level and saturate to 0..one
    always_comb begin
        for (int c = 0; c < hhr_pkg::NUM_CH; c++) begin
            if (r_p[c].neg) begin
                sum[c] = hhr_pkg::SUM_W'(r_p[c].base)
                       - $signed(hhr_pkg::SUM_W'(r_p[c].prod));
            end else begin
                sum[c] = hhr_pkg::SUM_W'(r_p[c].base)
                       + $signed(hhr_pkg::SUM_W'(r_p[c].prod));
            end
            if (sum[c][hhr_pkg::SUM_W-1]) begin
                n_out[c] = '0;
            end else if (sum[c] > $signed(hhr_pkg::SUM_W'(hhr_pkg::ONE))) begin
                n_out[c] = hhr_pkg::ONE;
            end else begin
                n_out[c] = sum[c][hhr_pkg::VAL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (o_rdy) begin
            r_o_vld <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p_vld && o_rdy) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_o_vld;
    assign o_red   = r_out[hhr_pkg::CH_RED];
    assign o_green = r_out[hhr_pkg::CH_GREEN];
    assign o_blue  = r_out[hhr_pkg::CH_BLUE];

    `HHR_ASSERT_NOW(a_out_range, o_valid,
        (o_red <= hhr_pkg::ONE) && (o_green <= hhr_pkg::ONE) && (o_blue <= hhr_pkg::ONE),
        "result above one")

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int     VAL_W           = hhr_pkg::VAL_W;
    localparam int     HUE_W           = hhr_pkg::HUE_W;
    localparam int     FB              = hhr_pkg::FRAC_BITS;
    localparam longint UNITY           = longint'(1) << hhr_pkg::FRAC_BITS;
    localparam int     CYCLE_LIMIT     = 200000;
    localparam int     HOLD_OFF_CYCLES = 300;
    localparam int     BLOCK_PIXELS    = 330;
    localparam int     NUM_CORNERS     = 13;

    // Corner pixels: sextant edges, half lightness, zero and full saturation, clamped fields
    localparam int CORNER_HUE[NUM_CORNERS] = '{0, 4095, 0, 682, 683, 1365, 1366, 2048,
                                               2048, 2731, 3413, 3414, 2730};
    localparam int CORNER_SAT[NUM_CORNERS] = '{0, 4096, 4096, 4096, 4096, 3000, 3000,
                                               2000, 2500, 8191, 1234, 4096, 0};
    localparam int CORNER_LVL[NUM_CORNERS] = '{0, 4096, 4096, 4096, 4096, 3500, 3500,
                                               2048, 2049, 8191, 4000, 1, 3000};

    typedef struct packed {
        logic [VAL_W-1:0] red;
        logic [VAL_W-1:0] green;
        logic [VAL_W-1:0] blue;
    } t_pixel_rgb;

    // Colour predictor and store of expected pixels
    class t_rgb_scoreboard;
        hhr_pkg::t_space space;
        t_pixel_rgb      expected_rgb[$];
        int              errors;

        function new();
            space  = hhr_pkg::SPACE_HSV;
            errors = 0;
        endfunction

        function int pending();
            return expected_rgb.size();
        endfunction

        // Product that drops the fraction bits, truncating toward zero
        function longint mul_frac(longint a, longint b);
            bit     neg;
            longint ua;
            longint ub;
            longint p;
            neg = (a < 0) != (b < 0);
            ua  = (a < 0) ? -a : a;
            ub  = (b < 0) ? -b : b;
            p   = (ua * ub) >> FB;
            return neg ? -p : p;
        endfunction

        function longint clamp_field(logic [VAL_W-1:0] x);
            return (longint'(x) > UNITY) ? UNITY : longint'(x);
        endfunction

        function logic [VAL_W-1:0] limit_out(longint x);
            if (x < 0) return '0;
            if (x > UNITY) return VAL_W'(UNITY);
            return VAL_W'(x);
        endfunction

        // Piecewise hue ramp between the two HLS levels
        function longint hls_ramp(longint lo, longint hi, longint y);
            while (y >= 6 * UNITY) y -= 6 * UNITY;
            while (y < 0) y += 6 * UNITY;
            if (y < UNITY) return lo + mul_frac(hi - lo, y);
            if (y < 3 * UNITY) return hi;
            if (y < 4 * UNITY) return lo + mul_frac(hi - lo, 4 * UNITY - y);
            return lo;
        endfunction

        function t_pixel_rgb predict_rgb(logic [HUE_W-1:0] hue, logic [VAL_W-1:0] sat_in,
                                         logic [VAL_W-1:0] lvl_in);
            longint     x;
            longint     s;
            longint     v;
            longint     f;
            longint     p1;
            longint     p2;
            longint     p3;
            longint     m1;
            longint     m2;
            longint     r;
            longint     g;
            longint     b;
            t_pixel_rgb px;
            x = longint'(hue) * 6;
            s = clamp_field(sat_in);
            v = clamp_field(lvl_in);
            if (space == hhr_pkg::SPACE_HSV) begin
                f  = x & (UNITY - 1);
                p1 = mul_frac(v, UNITY - s);
                p2 = mul_frac(v, UNITY - mul_frac(s, f));
                p3 = mul_frac(v, UNITY - mul_frac(s, UNITY - f));
                case (x >> FB)
                    0: begin r = v;  g = p3; b = p1; end
                    1: begin r = p2; g = v;  b = p1; end
                    2: begin r = p1; g = v;  b = p3; end
                    3: begin r = p1; g = p2; b = v;  end
                    4: begin r = p3; g = p1; b = v;  end
                    default: begin r = v; g = p1; b = p2; end
                endcase
            end else if (s == 0) begin
                // Grey: every channel takes the lightness
                r = v;
                g = v;
                b = v;
            end else begin
                if (v <= UNITY / 2) m2 = mul_frac(v, UNITY + s);
                else m2 = v + s - mul_frac(v, s);
                m1 = 2 * v - m2;
                r  = hls_ramp(m1, m2, x + 2 * UNITY);
                g  = hls_ramp(m1, m2, x);
                b  = hls_ramp(m1, m2, x - 2 * UNITY);
            end
            px.red   = limit_out(r);
            px.green = limit_out(g);
            px.blue  = limit_out(b);
            return px;
        endfunction

        function void note_request(logic [HUE_W-1:0] hue, logic [VAL_W-1:0] sat_in,
                                   logic [VAL_W-1:0] lvl_in);
            expected_rgb.push_back(predict_rgb(hue, sat_in, lvl_in));
        endfunction

        task report_mismatch(string what, int got, int want);
            errors++;
            if (errors <= 200)
                $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        endtask

        task check_result(logic [VAL_W-1:0] red, logic [VAL_W-1:0] green,
                          logic [VAL_W-1:0] blue);
            t_pixel_rgb want;
            if (expected_rgb.size() == 0) begin
                report_mismatch("unexpected pixel, red", red, -1);
            end else begin
                want = expected_rgb.pop_front();
                if (red !== want.red) report_mismatch("red", red, want.red);
                if (green !== want.green) report_mismatch("green", green, want.green);
                if (blue !== want.blue) report_mismatch("blue", blue, want.blue);
            end
        endtask
    endclass

    logic             i_clk                = 1'b0;
    logic             i_rst_n              = 1'b0;
    logic             i_valid              = 1'b0;
    logic             o_ready;
    logic [HUE_W-1:0] i_hue                = '0;
    logic [VAL_W-1:0] i_saturation         = '0;
    logic [VAL_W-1:0] i_value_or_lightness = '0;
    logic             o_valid;
    logic             i_ready              = 1'b0;
    logic [VAL_W-1:0] o_red;
    logic [VAL_W-1:0] o_green;
    logic [VAL_W-1:0] o_blue;
    logic             i_cfg_we             = 1'b0;
    logic             i_cfg_data           = 1'b0;

    t_rgb_scoreboard score;
    int              send_idle_pct = 10;
    int              recv_idle_pct = 10;
    int              hold_off_reqs = 0;
    int              hold_off_done = 0;
    int              cycle_count   = 0;

    hsv_hls_to_rgb_converter uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_hue                (i_hue),
        .i_saturation         (i_saturation),
        .i_value_or_lightness (i_value_or_lightness),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_red                (o_red),
        .o_green              (o_green),
        .o_blue               (o_blue),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_data           (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("hsv_hls_to_rgb_converter test failed");
            $finish;
        end
    end

    // Check every pixel that leaves the block
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            score.check_result(o_red, o_green, o_blue);
    end

    // Drive ready: random back-pressure, plus a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_reqs != hold_off_done) begin
                hold_off_done++;
                for (int n = 0; n < HOLD_OFF_CYCLES; n++) begin
                    i_ready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one request, with random gaps ahead of it, and hold it until taken
    task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [VAL_W-1:0] sat_in,
                              input logic [VAL_W-1:0] lvl_in);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid              <= 1'b1;
        i_hue                <= hue;
        i_saturation         <= sat_in;
        i_value_or_lightness <= lvl_in;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        score.note_request(hue, sat_in, lvl_in);
    endtask

    // Drop valid and wait for every expected pixel
    task automatic drain();
        i_valid <= 1'b0;
        while (score.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_space(input hhr_pkg::t_space sp);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= sp;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        score.space  = sp;
    endtask

    // Mostly in range, some clamped, some at the edges and around one half
    function automatic logic [VAL_W-1:0] pick_level();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 10) return VAL_W'($urandom_range(8191, 4097));
        if (sel < 14) return VAL_W'(UNITY);
        if (sel < 18) return '0;
        if (sel < 26) return VAL_W'($urandom_range(2052, 2044));
        return VAL_W'($urandom_range(4096, 0));
    endfunction

    task automatic run_corners();
        for (int n = 0; n < NUM_CORNERS; n++)
            send_pixel(HUE_W'(CORNER_HUE[n]), VAL_W'(CORNER_SAT[n]), VAL_W'(CORNER_LVL[n]));
    endtask

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++) begin
            send_pixel(HUE_W'($urandom_range(4095)), pick_level(), pick_level());
            // Pause the sender until the block is empty
            if (n == count / 2) drain();
        end
    endtask

    initial begin
        score = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Corners in both spaces; HSV is the reset choice
        run_corners();
        drain();
        write_space(hhr_pkg::SPACE_HLS);
        run_corners();

        // Random blocks: alternate spaces, walk through the idling patterns
        for (int blk = 0; blk < 6; blk++) begin
            drain();
            write_space((blk % 2 == 1) ? hhr_pkg::SPACE_HLS : hhr_pkg::SPACE_HSV);
            case (blk / 2)
                0: begin send_idle_pct = 10; recv_idle_pct = 82; end
                1: begin send_idle_pct = 82; recv_idle_pct = 10; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            // Hold off the receiver while the sender keeps pushing
            if (blk == 4) hold_off_reqs++;
            run_random(BLOCK_PIXELS);
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (score.errors == 0 && score.pending() == 0) begin
            $display("hsv_hls_to_rgb_converter test passed");
        end else begin
            $display("hsv_hls_to_rgb_converter test failed");
        end
        $finish;
    end

endmodule
